/* design/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define MTBB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset
`define MTBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also covers the reset cycles
`define MTBB_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/mtbb_pkg.sv */
// Shared types, constants and helpers of the bar/beat converter.
// No dependencies.
package mtbb_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_W     = 59;
  localparam int IDX_W     = 3;
  localparam int NUM_W     = 6;
  localparam int LD_W      = 3;
  localparam int LOW_MAX   = 14;  // widest fraction shift plus two

  localparam logic [31:0] UNUSED_START = 32'hFFFF_FFFF;
  localparam logic [REG_W-1:0] ENTRY0_RESET = 59'd145241087982698496;
  localparam logic [REG_W-1:0] ENTRYN_RESET = 59'h0000_0000_FFFF_FFFF;

  localparam logic MODE_TIME = 1'b0;
  localparam logic MODE_BAR  = 1'b1;

  typedef logic [REG_W-1:0] entry_t;

  // Front stage result: chosen entry and offset from its start
  typedef struct packed {
    logic             mode;
    logic             sat;
    logic [31:0]      diff;
    logic [15:0]      bars;
    logic [31:0]      start;
    logic [15:0]      sbar;
    logic [NUM_W-1:0] num;
    logic [LD_W-1:0]  ld;
  } s0_t;

  // Side data carried along the divider cells
  typedef struct packed {
    logic               mode;
    logic               sat;
    logic [15:0]        sbar;
    logic [NUM_W-1:0]   num;
    logic               compound;
    logic               num_zero;
    logic               diff_nz;
    logic [LOW_MAX-1:0] low;
    logic [31:0]        time_out;
  } side_t;

  // Compound meter: numerator above 3 and a multiple of 3
  function automatic logic is_compound(input logic [NUM_W-1:0] num);
    logic hit;
    hit = 1'b0;
    for (int k = 2; k <= 21; k++) begin
      if (num == NUM_W'(3 * k)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* design/mtbb_front.sv */
// Front stage: picks the signature entry for a request and forms the offset.
// Depends on mtbb_pkg.
module mtbb_front #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic                                 mode,
  input  logic [31:0]                          query_time,
  input  logic [15:0]                          query_bar,
  input  mtbb_pkg::entry_t                     entries [mtbb_pkg::REG_COUNT],
  output logic                                 valid,
  output mtbb_pkg::s0_t                        s0
);
  import mtbb_pkg::*;

  logic [IDX_W-1:0] sel;
  logic             found;
  entry_t           e;
  s0_t              s0_next;

  // First entry past the query or unused ends the scan
  always_comb begin
    found = 1'b0;
    sel   = IDX_W'(TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!found && ((entries[i][31:0] == UNUSED_START) ||
          ((mode == MODE_BAR) ? (entries[i][47:32] > query_bar)
                              : (entries[i][31:0] > query_time)))) begin
        found = 1'b1;
        sel   = (i == 0) ? '0 : IDX_W'(i - 1);
      end
    end
  end

  // Offset from the chosen entry, clamped to its start
  always_comb begin
    e               = entries[sel];
    s0_next.mode    = mode;
    s0_next.start   = e[31:0];
    s0_next.sbar    = e[47:32];
    s0_next.num     = e[53:48];
    s0_next.ld      = e[58:56];
    s0_next.sat     = 1'b0;
    s0_next.diff    = '0;
    s0_next.bars    = '0;
    if (mode == MODE_BAR) begin
      if (query_bar < e[47:32]) s0_next.sat = 1'b1;
      else s0_next.bars = query_bar - e[47:32];
    end else begin
      if (query_time < e[31:0]) s0_next.sat = 1'b1;
      else s0_next.diff = query_time - e[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      s0 <= s0_next;
    end
  end

endmodule

/* design/mtbb_cell.sv */
// One restoring division step: one quotient bit per cell, side data rides along.
// Depends on mtbb_pkg.
module mtbb_cell #(
  parameter int QW = 29
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         v_in,
  input  logic [QW-1:0]                dq_in,
  input  logic [mtbb_pkg::NUM_W-1:0]   rem_in,
  input  mtbb_pkg::side_t              side_in,
  output logic                         v_out,
  output logic [QW-1:0]                dq_out,
  output logic [mtbb_pkg::NUM_W-1:0]   rem_out,
  output mtbb_pkg::side_t              side_out
);
  import mtbb_pkg::*;

  logic [NUM_W:0] trial;
  logic           ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_in, dq_in[QW-1]};
    ge    = trial >= {1'b0, side_in.num};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      dq_out   <= {dq_in[QW-2:0], ge};
      rem_out  <= ge ? NUM_W'(trial - {1'b0, side_in.num}) : trial[NUM_W-1:0];
      side_out <= side_in;
    end
  end

endmodule

/* design/musical_time_to_bar_beat_unit.sv */
// Top level of the bar/beat converter: config table, front stage, divider
// cell chain and output register. Depends on mtbb_pkg, mtbb_front, mtbb_cell.
//
// Usage:
// - Requests enter on in_valid/in_ready with mode, query_time, query_bar.
//   Mode 0 gives bar_number and beat_position; mode 1 gives bar_start_time.
// - Results leave on out_valid/out_ready, one per request, in order.
// - Signature entries are written through cfg_write/cfg_index/cfg_data,
//   one entry per cycle, while no request is in flight.
// - A request passes one front stage, one cell per quotient bit of the bar
//   division and one output stage.
// - Throughput is one request per cycle while results are taken; the cell chain sets the latency.
// - When the receiver stalls, the whole chain holds and in_ready drops
//   until the output register is taken.
// - Reset empties the chain and loads entry 0 with 4/4 at time 0, bar 0,
//   and marks all other entries unused.
module musical_time_to_bar_beat_unit #(
  parameter int TABLE_DEPTH   = 8,
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mtbb_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mtbb_pkg::REG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [31:0]                   query_time,
  input  logic [15:0]                   query_bar,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   bar_number,
  output logic [13:0]                   beat_position,
  output logic [31:0]                   bar_start_time,
  output logic                          saturated
);
  import mtbb_pkg::*;

  localparam int SH  = FRACTION_BITS + 2;
  localparam int SCW = 32 + (1 << LD_W) - 1;
  localparam int QW  = SCW - SH;
  localparam int TW  = 2 * NUM_W + 10 + SH;
  localparam int SW  = ((TW > 32) ? TW : 32) + 1;
  localparam int QTW = NUM_W + SH - 2;
  localparam int DS  = QTW + 2;
  localparam logic [DS-1:0] RECIP3 = DS'((2 ** DS + 2) / 3);

  entry_t entries [REG_COUNT];
  logic   en;
  logic   v0;
  s0_t    s0;

  logic               v_c    [QW+1];
  logic [QW-1:0]      dq_c   [QW+1];
  logic [NUM_W-1:0]   rem_c  [QW+1];
  side_t              side_c [QW+1];

  logic [SCW-1:0]       scaled;
  logic [21:0]          tprod;
  logic [TW-1:0]        tsh;
  logic [SW-1:0]        tsum;
  logic [QW:0]          bsum;
  logic [QTW-1:0]       quarter;
  logic [QTW+DS-1:0]    prod3;
  logic [QTW-1:0]       beat_raw;
  side_t                fin;
  logic [15:0]          bar_next;
  logic [13:0]          beat_next;
  logic                 sat_next;

  // Whole chain advances unless a finished result is stuck
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Signature table
  always_ff @(posedge clk) begin
    if (rst) begin
      entries[0] <= ENTRY0_RESET;
      for (int i = 1; i < REG_COUNT; i++) entries[i] <= ENTRYN_RESET;
    end else if (cfg_write) begin
      entries[cfg_index] <= cfg_data;
    end
  end

  mtbb_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .mode       (mode),
    .query_time (query_time),
    .query_bar  (query_bar),
    .entries    (entries),
    .valid      (v0),
    .s0         (s0)
  );

  // Dividend setup for mode 0, start time for mode 1
  always_comb begin
    scaled = {{(SCW-32){1'b0}}, s0.diff} << s0.ld;
    tprod  = 22'(s0.bars) * 22'(s0.num);
    tsh    = (TW'(tprod) << SH) >> s0.ld;
    tsum   = SW'(s0.start) + SW'(tsh);

    v_c[0]   = v0;
    dq_c[0]  = scaled[SCW-1:SH];
    rem_c[0] = '0;
    side_c[0].mode     = s0.mode;
    side_c[0].sbar     = s0.sbar;
    side_c[0].num      = s0.num;
    side_c[0].compound = is_compound(s0.num);
    side_c[0].num_zero = (s0.num == '0);
    side_c[0].diff_nz  = (s0.diff != '0);
    side_c[0].low      = LOW_MAX'(scaled[SH-1:0]);
    side_c[0].sat      = s0.sat;
    side_c[0].time_out = s0.start;
    if (s0.mode == MODE_BAR) begin
      if (s0.num == '0) begin
        side_c[0].time_out = s0.start;
      end else if (tsum > SW'(32'hFFFF_FFFF)) begin
        side_c[0].time_out = 32'hFFFF_FFFF;
        side_c[0].sat      = 1'b1;
      end else begin
        side_c[0].time_out = tsum[31:0];
      end
    end
  end

  // Divider cell chain
  for (genvar g = 0; g < QW; g++) begin : g_cell
    mtbb_cell #(.QW(QW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (v_c[g]),
      .dq_in    (dq_c[g]),
      .rem_in   (rem_c[g]),
      .side_in  (side_c[g]),
      .v_out    (v_c[g+1]),
      .dq_out   (dq_c[g+1]),
      .rem_out  (rem_c[g+1]),
      .side_out (side_c[g+1])
    );
  end

  // Bar sum, beat scaling and saturation
  always_comb begin
    fin      = side_c[QW];
    bsum     = (QW+1)'(fin.sbar) + (QW+1)'(dq_c[QW]);
    quarter  = QTW'({rem_c[QW], fin.low[SH-1:0]} >> 2);
    prod3    = (QTW+DS)'(quarter) * (QTW+DS)'(RECIP3);
    beat_raw = fin.compound ? QTW'(prod3 >> DS) : quarter;
    sat_next  = fin.sat;
    bar_next  = '0;
    beat_next = '0;
    if (fin.mode == MODE_TIME) begin
      if (fin.num_zero) begin
        if (fin.diff_nz) begin
          bar_next = 16'hFFFF;
          sat_next = 1'b1;
        end else begin
          bar_next = fin.sbar;
        end
      end else begin
        if (bsum > (QW+1)'(16'hFFFF)) begin
          bar_next = 16'hFFFF;
          sat_next = 1'b1;
        end else begin
          bar_next = bsum[15:0];
        end
        if (32'(beat_raw) > 32'd16383) begin
          beat_next = 14'h3FFF;
          sat_next  = 1'b1;
        end else begin
          beat_next = 14'(beat_raw);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_c[QW];
    end
    if (en && v_c[QW]) begin
      bar_number     <= bar_next;
      beat_position  <= beat_next;
      bar_start_time <= (fin.mode == MODE_BAR) ? fin.time_out : '0;
      saturated      <= sat_next;
    end
  end

endmodule

/* design/mtbb_checker.sv */
// Port-level checks of the bar/beat converter, bound to the top level.
// Depends on assert_macros.svh and musical_time_to_bar_beat_unit.
`include "assert_macros.svh"

module mtbb_props (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] bar_number,
  input logic [13:0] beat_position,
  input logic [31:0] bar_start_time
);

  // Reset empties the output
  `MTBB_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid)
  // Intake follows the output register's state
  `MTBB_ASSERT(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))
  // A result carries either bar/beat or a start time, never both
  `MTBB_ASSERT(a_mode_fields, out_valid,
    (bar_start_time == 32'd0) || (bar_number == 16'd0 && beat_position == 14'd0))
  // A stalled result stays
  `MTBB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)

endmodule

bind musical_time_to_bar_beat_unit mtbb_props u_mtbb_props (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .bar_number     (bar_number),
  .beat_position  (beat_position),
  .bar_start_time (bar_start_time)
);

/* tb/mtbb_checker.sv */
// Scoreboard for the bar/beat converter: mirrors the signature table, predicts
// each request's result and compares it field by field. Depends on mtbb_pkg.
`timescale 1ns / 1ps

module mtbb_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [mtbb_pkg::IDX_W-1:0] cfg_index,
  input  logic [mtbb_pkg::REG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       mode,
  input  logic [31:0]                query_time,
  input  logic [15:0]                query_bar,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [15:0]                bar_number,
  input  logic [13:0]                beat_position,
  input  logic [31:0]                bar_start_time,
  input  logic                       saturated,
  output int                         errors,
  output int                         pending,
  output int                         results
);
  import mtbb_pkg::*;

  typedef struct packed {
    logic [15:0] bar;
    logic [13:0] beat;
    logic [31:0] tstart;
    logic        sat;
  } conv_t;

  entry_t sig_table [REG_COUNT];
  conv_t  conv_q [$];

  assign pending = conv_q.size();

  // Entry before the first one whose key passes the query or that is unused
  function automatic entry_t pick_entry(input logic by_bar, input logic [31:0] q);
    logic [31:0] key;
    for (int i = 0; i < REG_COUNT; i++) begin
      key = by_bar ? {16'd0, sig_table[i][47:32]} : sig_table[i][31:0];
      if (sig_table[i][31:0] == UNUSED_START || key > q)
        return sig_table[(i == 0) ? 0 : i - 1];
    end
    return sig_table[REG_COUNT-1];
  endfunction

  function automatic conv_t convert(input logic md, input logic [31:0] t,
                                    input logic [15:0] b);
    conv_t  r;
    entry_t e;
    logic [63:0] diff, scaled, len, nbar, rem, bpb, beat, bars, tout, num;
    r = '0;
    if (md == MODE_TIME) begin
      e = pick_entry(1'b0, t);
      num = {58'd0, e[53:48]};
      if (t < e[31:0]) begin
        diff = 0;
        r.sat = 1'b1;
      end else begin
        diff = {32'd0, t - e[31:0]};
      end
      if (num == 0) begin
        if (diff > 0) begin
          r.bar = 16'hFFFF;
          r.sat = 1'b1;
        end else begin
          r.bar = e[47:32];
        end
      end else begin
        scaled = diff << e[58:56];
        len    = num << 10;
        rem    = scaled % len;
        nbar   = {48'd0, e[47:32]} + scaled / len;
        bpb    = (num > 3 && num % 3 == 0) ? num / 3 : num;
        if (nbar > 64'hFFFF) begin
          nbar  = 64'hFFFF;
          r.sat = 1'b1;
        end
        beat = (rem * bpb) / (num * 4);
        if (beat > 64'h3FFF) begin
          beat  = 64'h3FFF;
          r.sat = 1'b1;
        end
        r.bar  = nbar[15:0];
        r.beat = beat[13:0];
      end
    end else begin
      e = pick_entry(1'b1, {16'd0, b});
      if (b < e[47:32]) begin
        bars  = 0;
        r.sat = 1'b1;
      end else begin
        bars = {48'd0, b - e[47:32]};
      end
      tout = {32'd0, e[31:0]} + (((bars * e[53:48]) << 10) >> e[58:56]);
      if (tout > 64'hFFFF_FFFF) begin
        tout  = 64'hFFFF_FFFF;
        r.sat = 1'b1;
      end
      r.tstart = tout[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    conv_t want;
    if (rst) begin
      sig_table[0] = ENTRY0_RESET;
      for (int i = 1; i < REG_COUNT; i++) sig_table[i] = ENTRYN_RESET;
      conv_q.delete();
      errors  = 0;
      results = 0;
    end else begin
      // compare a result against the oldest prediction
      if (out_valid && out_ready) begin
        results++;
        if (conv_q.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          want = conv_q.pop_front();
          if (bar_number !== want.bar) begin
            $error("bar_number: expected %0d, got %0d", want.bar, bar_number);
            errors++;
          end
          if (beat_position !== want.beat) begin
            $error("beat_position: expected %0d, got %0d", want.beat, beat_position);
            errors++;
          end
          if (bar_start_time !== want.tstart) begin
            $error("bar_start_time: expected %0d, got %0d", want.tstart, bar_start_time);
            errors++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, saturated);
            errors++;
          end
        end
      end
      // predict from the table as it stands before this edge
      if (in_valid && in_ready) conv_q.push_back(convert(mode, query_time, query_bar));
      if (cfg_write) sig_table[cfg_index] = cfg_data;
    end
  end
endmodule

/* tb/tb_musical_time_to_bar_beat_unit.sv */
// Top of the bar/beat converter testbench: clock, reset, table setup, request
// stimulus and verdict. Depends on mtbb_pkg, mtbb_checker and the block.
`timescale 1ns / 1ps

module tb_musical_time_to_bar_beat_unit;
  import mtbb_pkg::*;

  localparam int LATENCY  = 35;
  localparam int WD_LIMIT = 2000;

  logic                clk, rst;
  logic                cfg_write;
  logic [IDX_W-1:0]    cfg_index;
  logic [REG_W-1:0]    cfg_data;
  logic                in_valid, in_ready, mode;
  logic [31:0]         query_time;
  logic [15:0]         query_bar;
  logic                out_valid, out_ready;
  logic [15:0]         bar_number;
  logic [13:0]         beat_position;
  logic [31:0]         bar_start_time;
  logic                saturated;
  int                  errors, pending, results;
  int                  stall_cnt, sent, tables;
  logic                no_idle;
  entry_t              tbl [REG_COUNT];

  musical_time_to_bar_beat_unit dut (.*);
  mtbb_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WD_LIMIT) begin
      $display("musical_time_to_bar_beat_unit verification failed");
      $finish;
    end
  end

  // Receiver: random hold-off before taking each result
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      n = no_idle ? 0 : $urandom_range(3);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  function automatic entry_t pack(input logic [2:0] ld, input logic [5:0] num,
                                  input logic [15:0] bar, input logic [31:0] st);
    return {ld, 2'b00, num, bar, st};
  endfunction

  task automatic send(input logic md, input logic [31:0] t, input logic [15:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= md;
    query_time <= t;
    query_bar  <= b;
    @(posedge clk iff in_ready);
    sent++;
  endtask

  // Wait until every request has been answered and the chain has drained
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic load_table;
    @(posedge clk);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= tbl[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    tables++;
  endtask

  // Table with random content, sorted except in style 2 (all random bits); style picks the corner flavor
  task automatic make_table(input int style);
    int          used;
    logic [31:0] st;
    logic [15:0] br;
    used = (style == 1) ? REG_COUNT : $urandom_range(1, REG_COUNT);
    st   = ($urandom_range(1) == 0) ? 32'd0 : $urandom_range(20000);
    br   = 16'($urandom_range(100));
    for (int i = 0; i < REG_COUNT; i++) begin
      if (style == 2) begin
        tbl[i] = REG_W'({$urandom, $urandom});
      end else if (i < used) begin
        tbl[i] = pack(3'($urandom_range(7)),
                      ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 12)),
                      br, st);
        if (style == 3) tbl[i][31:0] = st + 32'hF000_0000 - 32'd100000;
        st = st + $urandom_range(1, 50000);
        br = br + 16'($urandom_range(0, (style == 3) ? 16383 : 200));
      end else begin
        tbl[i] = {27'($urandom), UNUSED_START};
      end
    end
  endtask

  task automatic random_query;
    int          k;
    logic [31:0] t;
    if ($urandom_range(4) == 0) begin
      t = $urandom;
      if (t == 32'hFFFF_FFFF) t = 32'hFFFF_FFFE;
      send(1'($urandom_range(1)), t, 16'($urandom));
    end else begin
      k = $urandom_range(REG_COUNT - 1);
      t = tbl[k][31:0] + $urandom_range(0, 70000) - 32'd500;
      if (t == 32'hFFFF_FFFF) t = 32'd0;
      send(1'($urandom_range(1)), t,
           tbl[k][47:32] + 16'($urandom_range(0, 300)) - 16'd5);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    mode       <= MODE_TIME;
    query_time <= '0;
    query_bar  <= '0;
    no_idle    = 1'b0;
    sent       = 0;
    tables     = 0;
    tbl[0]     = ENTRY0_RESET;
    for (int i = 1; i < REG_COUNT; i++) tbl[i] = ENTRYN_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset table: 4/4 from time zero
    send(MODE_TIME, 32'd0, 16'd0);
    send(MODE_TIME, 32'd1, 16'd0);
    send(MODE_TIME, 32'd1023, 16'd0);
    send(MODE_TIME, 32'd1024, 16'd0);
    send(MODE_TIME, 32'hFFFF_FFFE, 16'hFFFF);
    send(MODE_BAR, 32'hFFFF_FFFE, 16'd0);
    send(MODE_BAR, 32'd0, 16'd1);
    send(MODE_BAR, 32'd0, 16'hFFFF);
    drain();

    // corner table: late first entry, zero numerator, compound, overflow
    tbl[0] = pack(3'd2, 6'd0, 16'd10, 32'd1000);
    tbl[1] = pack(3'd3, 6'd6, 16'd20, 32'd5000);
    tbl[2] = pack(3'd0, 6'd63, 16'd65530, 32'd4294967000);
    tbl[3] = pack(3'd7, 6'd12, 16'd65535, 32'd4294967200);
    for (int i = 4; i < REG_COUNT; i++) tbl[i] = ENTRYN_RESET;
    load_table();
    send(MODE_TIME, 32'd5, 16'd0);
    send(MODE_TIME, 32'd1000, 16'd0);
    send(MODE_TIME, 32'd1001, 16'd0);
    send(MODE_TIME, 32'd6000, 16'd0);
    send(MODE_TIME, 32'd4000000, 16'd0);
    send(MODE_TIME, 32'd4294967100, 16'd0);
    send(MODE_TIME, 32'hFFFF_FFFE, 16'd0);
    send(MODE_BAR, 32'd0, 16'd0);
    send(MODE_BAR, 32'd0, 16'd15);
    send(MODE_BAR, 32'd0, 16'd25);
    send(MODE_BAR, 32'd0, 16'd65534);
    send(MODE_BAR, 32'd0, 16'hFFFF);
    drain();

    // random phases over varied tables
    for (int ph = 0; ph < 9; ph++) begin
      make_table(ph % 4);
      load_table();
      no_idle = (ph == 4);
      for (int n = 0; n < 80; n++) begin
        random_query();
        if (ph == 6 && n == 40) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (pending != 0);
          @(posedge clk);
        end
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    $display("Ran %0d requests over %0d signature tables, %0d results checked,",
             sent, tables, results);
    $display("covering both modes, clamped queries, zero and compound meters.");
    if (errors == 0)
      $display("musical_time_to_bar_beat_unit verification clean");
    else
      $display("musical_time_to_bar_beat_unit verification failed");
    $finish;
  end
endmodule
